>>> hw/rtl/scss_pkg.sv
// Shared constants, widths and the step delay table for the commutation sequencer.
`timescale 1ns / 1ps

package scss_pkg;

    // Field widths.
    localparam int unsigned SPEED_W = 8;
    localparam int unsigned STEP_W  = 3;
    localparam int unsigned PIN_W   = 6;

    // Speed clamp, table top and countdown width.
    localparam int unsigned MAX_SPEED   = 160;
    localparam int unsigned ROM_TOP     = 160;
    localparam int unsigned DELAY_WIDTH = 19;

    // Reset value of the minimum speed register.
    localparam logic [SPEED_W-1:0] MIN_SPEED_RESET = 8'd5;

    // Largest countdown value that fits in DELAY_WIDTH bits.
    localparam logic [31:0] DELAY_LIMIT = 32'((64'd1 << DELAY_WIDTH) - 64'd1);

    // Step delay in microseconds for each speed.
    localparam logic [31:0] DELAY_ROM [0:ROM_TOP] = '{
        32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd314278, 32'd269123, 32'd235314,
        32'd209051, 32'd188062, 32'd170904, 32'd156614, 32'd144530, 32'd134177,
        32'd125208, 32'd117363, 32'd110443, 32'd104293, 32'd98793, 32'd93843,
        32'd89366, 32'd85296, 32'd81581, 32'd78177, 32'd75044, 32'd72154,
        32'd69477, 32'd66993, 32'd64679, 32'd62520, 32'd60501, 32'd58608,
        32'd56830, 32'd55156, 32'd53579, 32'd52089, 32'd50679, 32'd49344,
        32'd48078, 32'd46875, 32'd45730, 32'd44640, 32'd43601, 32'd42609,
        32'd41662, 32'd40755, 32'd39887, 32'd39056, 32'd38258, 32'd37492,
        32'd36757, 32'd36049, 32'd35368, 32'd34713, 32'd34081, 32'd33472,
        32'd32885, 32'd32317, 32'd31769, 32'd31239, 32'd30727, 32'd30231,
        32'd29751, 32'd29286, 32'd28835, 32'd28398, 32'd27974, 32'd27562,
        32'd27162, 32'd26774, 32'd26397, 32'd26030, 32'd25673, 32'd25326,
        32'd24988, 32'd24659, 32'd24339, 32'd24027, 32'd23722, 32'd23426,
        32'd23136, 32'd22854, 32'd22579, 32'd22310, 32'd22047, 32'd21791,
        32'd21540, 32'd21295, 32'd21056, 32'd20822, 32'd20593, 32'd20369,
        32'd20150, 32'd19935, 32'd19725, 32'd19520, 32'd19318, 32'd19121,
        32'd18928, 32'd18739, 32'd18553, 32'd18371, 32'd18193, 32'd18018,
        32'd17846, 32'd17678, 32'd17512, 32'd17350, 32'd17191, 32'd17035,
        32'd16881, 32'd16730, 32'd16582, 32'd16437, 32'd16294, 32'd16153,
        32'd16015, 32'd15879, 32'd15746, 32'd15614, 32'd15485, 32'd15358,
        32'd15234, 32'd15111, 32'd14990, 32'd14871, 32'd14754, 32'd14638,
        32'd14525, 32'd14413, 32'd14303, 32'd14195, 32'd14088, 32'd13983,
        32'd13879, 32'd13777, 32'd13676, 32'd13577, 32'd13480, 32'd13383,
        32'd13288, 32'd13195, 32'd13102, 32'd13011, 32'd12922, 32'd12833,
        32'd12746, 32'd12660, 32'd12575, 32'd12491, 32'd12408, 32'd12326,
        32'd12246, 32'd12166, 32'd12088, 32'd12010, 32'd11934, 32'd11858,
        32'd11784, 32'd11710, 32'd11637
    };

endpackage

>>> hw/rtl/scss_if.sv
// Handshake interfaces for the tick, result and configuration channels.
`timescale 1ns / 1ps

interface scss_tick_if;
    logic                          valid;
    logic                          ready;
    logic [scss_pkg::SPEED_W-1:0]  speed_kmh;

    modport source (output valid, output speed_kmh, input ready);
    modport sink   (input valid, input speed_kmh, output ready);
endinterface

interface scss_result_if;
    logic                          valid;
    logic                          ready;
    logic                          inhibit_a;
    logic                          inhibit_b;
    logic                          inhibit_c;
    logic                          drive_a;
    logic                          drive_b;
    logic                          drive_c;
    logic [scss_pkg::STEP_W-1:0]   phase_step;

    modport source (output valid, output inhibit_a, output inhibit_b, output inhibit_c,
                    output drive_a, output drive_b, output drive_c, output phase_step,
                    input ready);
    modport sink   (input valid, input inhibit_a, input inhibit_b, input inhibit_c,
                    input drive_a, input drive_b, input drive_c, input phase_step,
                    output ready);
endinterface

interface scss_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [scss_pkg::SPEED_W-1:0]  min_speed;

    modport source (output valid, output min_speed, input ready);
    modport sink   (input valid, input min_speed, output ready);
endinterface

>>> hw/rtl/scss_delay_rom.sv
// Step delay lookup: clamps the speed to the table and saturates to the countdown width.
`timescale 1ns / 1ps

module scss_delay_rom (
    input  logic [scss_pkg::SPEED_W-1:0]     speed,
    output logic [scss_pkg::DELAY_WIDTH-1:0] delay
);

    logic [scss_pkg::SPEED_W-1:0] idx;
    logic [31:0]                  entry;

    // Speeds past the end of the table use the last entry.
    assign idx = (speed > scss_pkg::SPEED_W'(scss_pkg::ROM_TOP))
               ? scss_pkg::SPEED_W'(scss_pkg::ROM_TOP) : speed;

    assign entry = scss_pkg::DELAY_ROM[idx];

    // A delay wider than the countdown saturates to all ones.
    assign delay = (entry > scss_pkg::DELAY_LIMIT)
                 ? {scss_pkg::DELAY_WIDTH{1'b1}}
                 : scss_pkg::DELAY_WIDTH'(entry);

endmodule

>>> hw/rtl/scss_core.sv
// Step state, countdown and pin update with the registered result stage.
`timescale 1ns / 1ps

module scss_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [scss_pkg::SPEED_W-1:0]  min_speed,
    scss_tick_if.sink                     tick,
    scss_result_if.source                 result
);

    typedef enum logic [scss_pkg::STEP_W-1:0] {
        STEP_OFF = 3'd0,
        STEP_1   = 3'd1,
        STEP_2   = 3'd2,
        STEP_3   = 3'd3,
        STEP_4   = 3'd4,
        STEP_5   = 3'd5,
        STEP_6   = 3'd6
    } step_t;

    step_t                              step_state_reg, step_state_next;
    logic [scss_pkg::DELAY_WIDTH-1:0]   remaining_reg, remaining_next;
    logic [scss_pkg::PIN_W-1:0]         pins_reg, pins_next;
    logic                               out_valid_reg, out_valid_next;
    logic [scss_pkg::PIN_W-1:0]         out_pins_reg;
    step_t                              out_step_reg;

    logic [scss_pkg::SPEED_W-1:0]       speed;
    logic [scss_pkg::DELAY_WIDTH-1:0]   delay;
    logic                               accept;
    logic                               go;
    logic                               stepping;
    logic [scss_pkg::PIN_W-1:0]         mask;
    logic [scss_pkg::PIN_W-1:0]         value;
    step_t                              succ;
    step_t                              ran;

    // Clamp the incoming speed and look up its step delay.
    assign speed = (tick.speed_kmh > scss_pkg::SPEED_W'(scss_pkg::MAX_SPEED))
                 ? scss_pkg::SPEED_W'(scss_pkg::MAX_SPEED) : tick.speed_kmh;

    scss_delay_rom u_rom (
        .speed (speed),
        .delay (delay)
    );

    // A new item is taken whenever the result register is empty or being drained.
    assign tick.ready = !out_valid_reg || result.ready;
    assign accept     = tick.valid && tick.ready;
    assign go         = (speed >= min_speed);

    // Pins that each step writes, the levels it writes, and the step that follows.
    always_comb
    begin
        stepping = 1'b1;
        case (step_state_reg)
            STEP_1:
            begin
                mask = 6'h2F; value = 6'h0B; succ = STEP_2;
            end
            STEP_2:
            begin
                mask = 6'h06; value = 6'h04; succ = STEP_3;
            end
            STEP_3:
            begin
                mask = 6'h1B; value = 6'h12; succ = STEP_4;
            end
            STEP_4:
            begin
                mask = 6'h05; value = 6'h01; succ = STEP_5;
            end
            STEP_5:
            begin
                mask = 6'h36; value = 6'h24; succ = STEP_6;
            end
            STEP_6:
            begin
                mask = 6'h03; value = 6'h02; succ = STEP_1;
            end
            default:
            begin
                // Off, and any unused code, clears every pin.
                stepping = 1'b0;
                mask = 6'h3F; value = 6'h00; succ = STEP_1;
            end
        endcase
    end

    // Next state for one tick.
    always_comb
    begin
        pins_next       = (pins_reg & ~mask) | value;
        step_state_next = step_state_reg;
        remaining_next  = remaining_reg;
        ran             = step_state_reg;
        if (!stepping)
        begin
            ran = STEP_OFF;
            if (go)
            begin
                step_state_next = STEP_1;
                remaining_next  = delay;
            end
            else
            begin
                step_state_next = STEP_OFF;
            end
        end
        else if (!go)
        begin
            step_state_next = STEP_OFF;
            remaining_next  = '0;
        end
        else if (remaining_reg <= scss_pkg::DELAY_WIDTH'(1))
        begin
            step_state_next = succ;
            remaining_next  = delay;
        end
        else
        begin
            remaining_next = remaining_reg - scss_pkg::DELAY_WIDTH'(1);
        end
    end

    // Result valid flag: set by an accepted item, cleared when taken.
    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // State and registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_state_reg <= STEP_OFF;
            remaining_reg  <= '0;
            pins_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                step_state_reg <= step_state_next;
                remaining_reg  <= remaining_next;
                pins_reg       <= pins_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_pins_reg <= pins_next;
            out_step_reg <= ran;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.inhibit_a  = out_pins_reg[0];
    assign result.inhibit_b  = out_pins_reg[1];
    assign result.inhibit_c  = out_pins_reg[2];
    assign result.drive_a    = out_pins_reg[3];
    assign result.drive_b    = out_pins_reg[4];
    assign result.drive_c    = out_pins_reg[5];
    assign result.phase_step = out_step_reg;

    // The countdown is idle while the drive is off.
    a_off_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (step_state_reg == STEP_OFF) |-> (remaining_reg == '0))
        else $error("countdown running while drive is off");

    // A tick taken in the off state reports off with all pins low.
    a_off_pins_low: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && step_state_reg == STEP_OFF)
        |=> (out_step_reg == STEP_OFF && out_pins_reg == '0))
        else $error("off tick produced a non-idle result");

    // The result register only changes when an item is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !accept) |=> ($stable(out_pins_reg) && $stable(out_step_reg)))
        else $error("result changed without an accepted item");

    // A stalled result blocks new items.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !tick.ready)
        else $error("item taken while result is stalled");

endmodule

>>> hw/rtl/six_step_commutation_sequencer.sv
// Top level of the six-step commutation sequencer with its configuration register.
//
// Usage: each item on the tick channel is one microsecond tick carrying the
// current speed (clamped to 160). For every item the block returns one result
// item on the result channel: the six inhibit and pwm pin levels after the tick
// and the step that ran (0 off, 1 to 6 commutation step).
// The cfg channel writes min_speed, the speed below which the drive is off; it
// is always ready and should be written only while no item is in flight.
// Latency: a result is valid the cycle after its tick is accepted.
// Throughput: one item per cycle while results are taken, set by the single
// registered update of the step state and countdown.
// Reset: the drive is off, all pins low, countdown zero, min_speed 5, and no
// result is pending.
// Stall: while a result waits with ready low, the tick channel is held off; it
// is ready again in the cycle the result is taken.
`timescale 1ns / 1ps

module six_step_commutation_sequencer (
    input  logic           clk,
    input  logic           rst_n,
    scss_tick_if.sink      tick,
    scss_result_if.source  result,
    scss_cfg_if.sink       cfg
);

    logic [scss_pkg::SPEED_W-1:0] min_speed_reg;

    // Configuration register.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_speed_reg <= scss_pkg::MIN_SPEED_RESET;
        else if (cfg.valid)
            min_speed_reg <= cfg.min_speed;
    end

    scss_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .min_speed (min_speed_reg),
        .tick      (tick),
        .result    (result)
    );

endmodule

>>> test/six_step_commutation_sequencer_test.sv
// Testbench for the six-step commutation sequencer: predicts every tick result and checks it.
`timescale 1ns / 1ps

module six_step_commutation_sequencer_test;

    localparam int unsigned CLK_HALF_NS     = 6;
    localparam int unsigned MAX_GAP         = 3;
    localparam int unsigned IDLE_LIMIT      = 1000;
    localparam int unsigned DRAIN_CYCLES    = 4;
    localparam int unsigned PRINT_LIMIT     = 40;
    localparam int unsigned COUNTDOWN_TICKS = 40;

    // Step codes.
    localparam logic [scss_pkg::STEP_W-1:0] STEP_OFF   = 3'd0;
    localparam logic [scss_pkg::STEP_W-1:0] STEP_FIRST = 3'd1;
    localparam logic [scss_pkg::STEP_W-1:0] STEP_LAST  = 3'd6;

    // Pin bits: 0 to 2 are inhibit a to c, 3 to 5 are drive a to c.
    // Each step owns some pins (mask) and forces them to fixed levels.
    localparam logic [scss_pkg::PIN_W-1:0] STEP_WRITE_MASK [0:6] =
        '{6'h3F, 6'h2F, 6'h06, 6'h1B, 6'h05, 6'h36, 6'h03};
    localparam logic [scss_pkg::PIN_W-1:0] STEP_WRITE_LEVEL [0:6] =
        '{6'h00, 6'h0B, 6'h04, 6'h12, 6'h01, 6'h24, 6'h02};

    typedef struct packed {
        logic [scss_pkg::STEP_W-1:0] phase_step;
        logic [scss_pkg::PIN_W-1:0]  pins;
    } tick_result_t;

    // Commutation predictor with the queue of expected pin results.
    class commutation_scoreboard;
        logic [scss_pkg::SPEED_W-1:0]     min_speed;
        logic [scss_pkg::STEP_W-1:0]      step;
        logic [scss_pkg::DELAY_WIDTH-1:0] countdown;
        logic [scss_pkg::PIN_W-1:0]       pins;
        tick_result_t                     expected_q[$];
        int unsigned                      mismatches;

        function new();
            min_speed  = scss_pkg::MIN_SPEED_RESET;
            step       = STEP_OFF;
            countdown  = '0;
            pins       = '0;
            mismatches = 0;
        endfunction

        function void set_min_speed(logic [scss_pkg::SPEED_W-1:0] value);
            min_speed = value;
        endfunction

        // Step delay for a clamped speed, saturated to the countdown width.
        function logic [scss_pkg::DELAY_WIDTH-1:0] step_delay(
            logic [scss_pkg::SPEED_W-1:0] spd);
            int unsigned idx;
            logic [31:0] delay_us;
            idx = (spd > scss_pkg::ROM_TOP) ? scss_pkg::ROM_TOP : int'(spd);
            delay_us = scss_pkg::DELAY_ROM[idx];
            if (delay_us > scss_pkg::DELAY_LIMIT)
            begin
                delay_us = scss_pkg::DELAY_LIMIT;
            end
            return delay_us[scss_pkg::DELAY_WIDTH-1:0];
        endfunction

        function string pin_name(int unsigned bit_idx);
            case (bit_idx)
                0: return "inhibit_a";
                1: return "inhibit_b";
                2: return "inhibit_c";
                3: return "drive_a";
                4: return "drive_b";
                default: return "drive_c";
            endcase
        endfunction

        // Advance the model by one accepted tick and queue its result.
        function void note_tick(logic [scss_pkg::SPEED_W-1:0] speed_in);
            logic [scss_pkg::SPEED_W-1:0] spd;
            logic [scss_pkg::STEP_W-1:0]  ran;
            tick_result_t                 want;
            spd = (speed_in > scss_pkg::MAX_SPEED)
                ? scss_pkg::SPEED_W'(scss_pkg::MAX_SPEED) : speed_in;
            ran = step;
            if (ran == STEP_OFF || ran > STEP_LAST)
            begin
                // Off clears every pin and starts at step one once fast enough.
                ran  = STEP_OFF;
                pins = '0;
                step = STEP_OFF;
                if (spd >= min_speed)
                begin
                    countdown = step_delay(spd);
                    step      = STEP_FIRST;
                end
            end
            else
            begin
                pins = (pins & ~STEP_WRITE_MASK[ran]) | STEP_WRITE_LEVEL[ran];
                if (spd < min_speed)
                begin
                    step      = STEP_OFF;
                    countdown = '0;
                end
                else if (countdown <= 1)
                begin
                    countdown = step_delay(spd);
                    step      = (ran == STEP_LAST) ? STEP_FIRST : ran + 3'd1;
                end
                else
                begin
                    countdown = countdown - 1'b1;
                end
            end
            want.phase_step = ran;
            want.pins       = pins;
            expected_q.push_back(want);
        endfunction

        task report(string msg);
            if (mismatches < PRINT_LIMIT)
            begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
            mismatches++;
        endtask

        // Compare one result item with the oldest expectation.
        task check_result(tick_result_t got);
            tick_result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result with no tick pending (step %0d)", got.phase_step));
                return;
            end
            want = expected_q.pop_front();
            if (got.phase_step !== want.phase_step)
            begin
                report($sformatf("phase_step %0d, expected %0d",
                                 got.phase_step, want.phase_step));
            end
            for (int unsigned i = 0; i < scss_pkg::PIN_W; i++)
            begin
                if (got.pins[i] !== want.pins[i])
                begin
                    report($sformatf("%s %b, expected %b at step %0d",
                                     pin_name(i), got.pins[i], want.pins[i],
                                     want.phase_step));
                end
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    scss_tick_if   tick();
    scss_result_if result();
    scss_cfg_if    cfg();

    commutation_scoreboard board = new();

    bit                           no_idle;
    logic [scss_pkg::SPEED_W-1:0] min_setting;
    int unsigned                  ticks_sent;
    int unsigned                  cycles_quiet;

    six_step_commutation_sequencer u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick),
        .result (result),
        .cfg    (cfg)
    );

    // Clock generation.
    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    // Send one tick after a random gap; the model advances when it is accepted.
    task send_tick(input logic [scss_pkg::SPEED_W-1:0] spd);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            tick.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick.valid     <= 1'b1;
        tick.speed_kmh <= spd;
        do @(posedge clk); while (tick.ready !== 1'b1);
        board.note_tick(spd);
        ticks_sent++;
    endtask

    // Stop sending and wait until every expected result has arrived.
    task drain_results();
        tick.valid <= 1'b0;
        do @(posedge clk); while (board.expected_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the minimum speed register while the block is idle.
    task write_min_speed(input logic [scss_pkg::SPEED_W-1:0] value);
        drain_results();
        cfg.valid     <= 1'b1;
        cfg.min_speed <= value;
        do @(posedge clk); while (cfg.ready !== 1'b1);
        cfg.valid <= 1'b0;
        board.set_min_speed(value);
        min_setting = value;
        no_idle = ($urandom_range(0, 3) == 0);
    endtask

    // Minimum speed 0: only zero-delay speeds, so the step advances every tick.
    task run_zero_delay(input int unsigned count);
        repeat (count) send_tick(scss_pkg::SPEED_W'($urandom_range(0, 4)));
    endtask

    // Minimum speed 1 to 4: mostly runs of zero-delay speeds that spin the
    // steps, mixed with noise, stops and long delays broken by a stop.
    task run_stepping_mix(input int unsigned count);
        int unsigned target;
        int unsigned pick;
        target = ticks_sent + count;
        while (ticks_sent < target)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 5)
            begin
                repeat ($urandom_range(1, 24))
                    send_tick(scss_pkg::SPEED_W'($urandom_range(int'(min_setting), 4)));
            end
            else if (pick <= 7)
            begin
                repeat ($urandom_range(1, 3))
                    send_tick(scss_pkg::SPEED_W'($urandom_range(0, 255)));
            end
            else if (pick == 8)
            begin
                send_tick(scss_pkg::SPEED_W'($urandom_range(0, int'(min_setting) - 1)));
            end
            else
            begin
                send_tick(scss_pkg::SPEED_W'($urandom_range(5, 255)));
                send_tick(scss_pkg::SPEED_W'($urandom_range(0, int'(min_setting) - 1)));
            end
        end
    endtask

    // Speeds spread over the whole field, weighted around the threshold.
    task run_speed_noise(input int unsigned count);
        int unsigned pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 2);
            if (pick == 0 || min_setting == 0)
            begin
                send_tick(scss_pkg::SPEED_W'($urandom_range(0, 255)));
            end
            else if (pick == 1)
            begin
                send_tick(scss_pkg::SPEED_W'($urandom_range(int'(min_setting), 255)));
            end
            else
            begin
                send_tick(scss_pkg::SPEED_W'($urandom_range(0, int'(min_setting) - 1)));
            end
        end
    endtask

    // Result side: random stalls, then check each accepted item.
    initial
    begin
        int unsigned  stall;
        tick_result_t got;
        result.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            do @(posedge clk); while (result.valid !== 1'b1);
            got.phase_step = result.phase_step;
            got.pins = {result.drive_c, result.drive_b, result.drive_a,
                        result.inhibit_c, result.inhibit_b, result.inhibit_a};
            board.check_result(got);
        end
    end

    // Watchdog: end the run when nothing moves on any channel for too long.
    initial
    begin
        cycles_quiet = 0;
        while (cycles_quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((tick.valid && tick.ready) || (result.valid && result.ready) ||
                (cfg.valid && cfg.ready))
            begin
                cycles_quiet = 0;
            end
            else
            begin
                cycles_quiet++;
            end
        end
        $display("FAIL six_step_commutation_sequencer");
        $finish;
    end

    // Main sequence.
    initial
    begin
        logic [scss_pkg::SPEED_W-1:0] directed_speeds [0:11];
        logic [scss_pkg::SPEED_W-1:0] mixed_mins [0:3];

        directed_speeds = '{8'd0, 8'd255, 8'd255, 8'd4, 8'd0, 8'd5,
                            8'd161, 8'd160, 8'd0, 8'd170, 8'd85, 8'd0};
        mixed_mins      = '{8'd4, 8'd3, 8'd1, 8'd2};

        rst_n          = 1'b0;
        no_idle        = 1'b0;
        ticks_sent     = 0;
        min_setting    = scss_pkg::MIN_SPEED_RESET;
        tick.valid     <= 1'b0;
        tick.speed_kmh <= '0;
        cfg.valid      <= 1'b0;
        cfg.min_speed  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset threshold: off hold, clamp, entry, stop and the bit patterns.
        foreach (directed_speeds[i]) send_tick(directed_speeds[i]);

        // Threshold zero: zero delays spin through all six steps.
        write_min_speed(8'd0);
        for (int unsigned i = 0; i < 14; i++) send_tick(scss_pkg::SPEED_W'(i % 5));
        run_zero_delay(150);

        // Low thresholds where zero delays, stops and long delays all occur.
        foreach (mixed_mins[i])
        begin
            write_min_speed(mixed_mins[i]);
            run_stepping_mix(260);
        end

        // Top threshold: entry at the shortest table delay, a run of countdown
        // ticks back to back, then a stop.
        write_min_speed(8'd160);
        no_idle = 1'b1;
        send_tick(scss_pkg::SPEED_W'($urandom_range(0, 159)));
        send_tick(scss_pkg::SPEED_W'($urandom_range(160, 255)));
        repeat (COUNTDOWN_TICKS) send_tick(scss_pkg::SPEED_W'($urandom_range(160, 255)));
        send_tick(scss_pkg::SPEED_W'($urandom_range(0, 159)));
        no_idle = 1'b0;
        run_speed_noise(150);

        // A random mid threshold, then back to the reset value.
        write_min_speed(scss_pkg::SPEED_W'($urandom_range(6, 159)));
        run_speed_noise(200);
        write_min_speed(scss_pkg::MIN_SPEED_RESET);
        run_speed_noise(100);

        drain_results();
        if (board.mismatches == 0)
        begin
            $display("PASS six_step_commutation_sequencer");
        end
        else
        begin
            $display("FAIL six_step_commutation_sequencer");
        end
        $finish;
    end

endmodule
